// File: sv/mwoc_pkg.sv
package mwoc_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_WORD_SLOTS     = 4;
    localparam int DEF_MAX_WORD_BYTES = 8;
    localparam int DEF_COUNT_BITS     = 16;

    // Fixed widths of the ports and of the configuration registers
    localparam int COUNT_PORT_BITS = 16;
    localparam int WORD_REG_BITS   = 64;
    localparam int LENGTH_BITS     = 4;
    localparam int LENGTHS_BITS    = 16;
    localparam int COOLDOWN_BITS   = 3;
    localparam int NUM_WORD_REGS   = 4;
    localparam int APB_DATA_BITS   = 64;
    localparam int APB_ADDR_BITS   = 6;
    localparam int REG_INDEX_BITS  = 3;

    // Register indexes on the configuration port (byte address is 8 times the index)
    localparam logic [REG_INDEX_BITS-1:0] REG_WORD_A  = 3'd0;
    localparam logic [REG_INDEX_BITS-1:0] REG_WORD_B  = 3'd1;
    localparam logic [REG_INDEX_BITS-1:0] REG_WORD_C  = 3'd2;
    localparam logic [REG_INDEX_BITS-1:0] REG_WORD_D  = 3'd3;
    localparam logic [REG_INDEX_BITS-1:0] REG_LENGTHS = 3'd4;

    // Item operation codes
    typedef enum logic [1:0] {
        OP_TEXT  = 2'd0,
        OP_EOL   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // Control handed from the top level to each word slot
    typedef struct packed {
        logic step;
        op_t  op;
    } slot_ctl_t;

endpackage

// File: sv/multi_word_occurrence_counter_core.sv
// Channel  | Signals                                            | Item moved
// ---------+----------------------------------------------------+-----------------------------
// item     | item_valid, item_stall, opcode, text_byte          | text byte, line end or clear
// result   | result_valid, result_stall, count_a..d, match_mask | all counts and the match mask
// config   | psel, penable, pwrite, paddr, pwdata, prdata       | word and length registers
//
// One item is accepted per cycle while item_stall is low; each result passes through
// the input register, then the compare and count update into the result register.
// Reset clears the line history, cooldowns, counts and both pipeline valid flags.
// A stall on the result side holds the result register and, once the input
// register is also full, raises item_stall in the same cycle.
module multi_word_occurrence_counter_core #(
    parameter int WORD_SLOTS     = mwoc_pkg::DEF_WORD_SLOTS,
    parameter int MAX_WORD_BYTES = mwoc_pkg::DEF_MAX_WORD_BYTES,
    parameter int COUNT_BITS     = mwoc_pkg::DEF_COUNT_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Item channel
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic [1:0]                          opcode,
    input  logic [7:0]                          text_byte,
    // Result channel
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [mwoc_pkg::COUNT_PORT_BITS-1:0] count_a,
    output logic [mwoc_pkg::COUNT_PORT_BITS-1:0] count_b,
    output logic [mwoc_pkg::COUNT_PORT_BITS-1:0] count_c,
    output logic [mwoc_pkg::COUNT_PORT_BITS-1:0] count_d,
    output logic [3:0]                          match_mask,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mwoc_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [mwoc_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [mwoc_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready
);

    localparam int HistW    = MAX_WORD_BYTES * 8;
    localparam int FillW    = $clog2(MAX_WORD_BYTES + 1);
    localparam int CntPortW = mwoc_pkg::COUNT_PORT_BITS;
    localparam int LenW     = mwoc_pkg::LENGTH_BITS;
    localparam int NumWords = mwoc_pkg::NUM_WORD_REGS;
    localparam int DataW    = mwoc_pkg::APB_DATA_BITS;
    localparam int IdxW     = mwoc_pkg::REG_INDEX_BITS;

    // Configuration registers
    logic [mwoc_pkg::WORD_REG_BITS-1:0] word_reg [NumWords];
    logic [mwoc_pkg::LENGTHS_BITS-1:0]  lengths_reg;
    logic [IdxW-1:0]                    reg_index;
    logic                               cfg_write;

    // Pipeline control
    logic              s1_valid_reg;
    mwoc_pkg::op_t     s1_op_reg;
    logic [7:0]        s1_byte_reg;
    logic              s2_valid_reg;
    logic              s1_load;
    logic              s2_step;

    // Line state
    logic [HistW-1:0]  hist_reg;
    logic [HistW-1:0]  hist_next;
    logic [FillW-1:0]  fill_reg;
    logic [FillW-1:0]  fill_next;

    mwoc_pkg::slot_ctl_t          slot_ctl;
    logic [COUNT_BITS-1:0]        slot_count [NumWords];
    logic [NumWords-1:0]          slot_hit;

    // Configuration port: always ready, written on the access cycle
    assign pready    = 1'b1;
    assign reg_index = paddr[mwoc_pkg::APB_ADDR_BITS-1 -: IdxW];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NumWords; i++)
            begin
                word_reg[i] <= '0;
            end
            lengths_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                mwoc_pkg::REG_WORD_A:  word_reg[0] <= pwdata;
                mwoc_pkg::REG_WORD_B:  word_reg[1] <= pwdata;
                mwoc_pkg::REG_WORD_C:  word_reg[2] <= pwdata;
                mwoc_pkg::REG_WORD_D:  word_reg[3] <= pwdata;
                mwoc_pkg::REG_LENGTHS: lengths_reg <= pwdata[mwoc_pkg::LENGTHS_BITS-1:0];
                default:               lengths_reg <= lengths_reg;
            endcase
        end
    end

    // Register read-back
    always_comb
    begin
        unique case (reg_index)
            mwoc_pkg::REG_WORD_A:  prdata = word_reg[0];
            mwoc_pkg::REG_WORD_B:  prdata = word_reg[1];
            mwoc_pkg::REG_WORD_C:  prdata = word_reg[2];
            mwoc_pkg::REG_WORD_D:  prdata = word_reg[3];
            mwoc_pkg::REG_LENGTHS: prdata = DataW'(lengths_reg);
            default:               prdata = '0;
        endcase
    end

    // Handshake: the result register moves when empty or taken, the input register behind it
    assign s2_step    = s1_valid_reg && (!s2_valid_reg || !result_stall);
    assign item_stall = s1_valid_reg && !s2_step;
    assign s1_load    = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s2_step)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s2_step)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_op_reg   <= mwoc_pkg::op_t'(opcode);
            s1_byte_reg <= text_byte;
        end
    end

    // Line history and fill count after this item
    always_comb
    begin
        hist_next = hist_reg;
        fill_next = fill_reg;
        case (s1_op_reg)
            mwoc_pkg::OP_TEXT:
            begin
                hist_next = HistW'({hist_reg, s1_byte_reg});
                if (fill_reg < FillW'(MAX_WORD_BYTES))
                begin
                    fill_next = fill_reg + 1'b1;
                end
            end
            mwoc_pkg::OP_EOL:
            begin
                hist_next = '0;
                fill_next = '0;
            end
            default:
            begin
                hist_next = hist_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= '0;
            fill_reg <= '0;
        end
        else if (s2_step)
        begin
            hist_reg <= hist_next;
            fill_reg <= fill_next;
        end
    end

    assign slot_ctl.step = s2_step;
    assign slot_ctl.op   = s1_op_reg;

    // One matcher and counter per word slot; unused slots report zero
    for (genvar s = 0; s < NumWords; s++)
    begin : g_slot
        if (s < WORD_SLOTS)
        begin : g_used
            mwoc_slot #(
                .MAX_WORD_BYTES (MAX_WORD_BYTES),
                .COUNT_BITS     (COUNT_BITS),
                .FILL_BITS      (FillW)
            ) u_slot (
                .clk   (clk),
                .rst_n (rst_n),
                .ctl   (slot_ctl),
                .word  (word_reg[s][HistW-1:0]),
                .len   (lengths_reg[s*LenW +: LenW]),
                .hist  (hist_next),
                .fill  (fill_next),
                .count (slot_count[s]),
                .hit   (slot_hit[s])
            );
        end
        else
        begin : g_unused
            assign slot_count[s] = '0;
            assign slot_hit[s]   = 1'b0;
        end
    end

    // Result payload comes straight from the slot registers
    assign result_valid = s2_valid_reg;
    assign count_a      = CntPortW'(slot_count[0]);
    assign count_b      = CntPortW'(slot_count[1]);
    assign count_c      = CntPortW'(slot_count[2]);
    assign count_d      = CntPortW'(slot_count[3]);
    assign match_mask   = slot_hit;

endmodule

// File: sv/mwoc_slot.sv
module mwoc_slot #(
    parameter int MAX_WORD_BYTES = mwoc_pkg::DEF_MAX_WORD_BYTES,
    parameter int COUNT_BITS     = mwoc_pkg::DEF_COUNT_BITS,
    parameter int FILL_BITS      = $clog2(MAX_WORD_BYTES + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mwoc_pkg::slot_ctl_t               ctl,
    input  logic [MAX_WORD_BYTES*8-1:0]       word,
    input  logic [mwoc_pkg::LENGTH_BITS-1:0]  len,
    input  logic [MAX_WORD_BYTES*8-1:0]       hist,
    input  logic [FILL_BITS-1:0]              fill,
    output logic [COUNT_BITS-1:0]             count,
    output logic                              hit
);

    localparam int LenW = mwoc_pkg::LENGTH_BITS;
    localparam int CdW  = mwoc_pkg::COOLDOWN_BITS;

    logic [CdW-1:0]            cd_reg;
    logic [CdW-1:0]            cd_next;
    logic [COUNT_BITS-1:0]     cnt_reg;
    logic [COUNT_BITS-1:0]     cnt_next;
    logic                      hit_reg;
    logic                      hit_next;
    logic [MAX_WORD_BYTES-1:0] tail_ok;
    logic                      tail_match;
    logic                      len_ok;

    // Compare the word against the line tail for every possible length at once.
    // Bit L-1 of tail_ok is set when the last L bytes equal the first L word bytes.
    always_comb
    begin
        int back;
        tail_ok = '1;
        for (int l = 1; l <= MAX_WORD_BYTES; l++)
        begin
            for (int j = 0; j < MAX_WORD_BYTES; j++)
            begin
                back = (j < l) ? (l - 1 - j) : 0;
                if (j < l && hist[back*8 +: 8] != word[j*8 +: 8])
                begin
                    tail_ok[l-1] = 1'b0;
                end
            end
        end
    end

    // Pick the result for the configured length; lengths above the maximum disable the slot.
    always_comb
    begin
        tail_match = 1'b0;
        for (int l = 1; l <= MAX_WORD_BYTES; l++)
        begin
            if (len == LenW'(l))
            begin
                tail_match = tail_ok[l-1];
            end
        end
    end

    assign len_ok = (len != '0) && (len <= LenW'(MAX_WORD_BYTES));

    // Cooldown, counter and hit flag for one item
    always_comb
    begin
        cd_next  = cd_reg;
        cnt_next = cnt_reg;
        hit_next = 1'b0;
        case (ctl.op)
            mwoc_pkg::OP_TEXT:
            begin
                if (cd_reg != '0)
                begin
                    cd_next = cd_reg - 1'b1;
                end
                else if (len_ok && LenW'(fill) >= len && tail_match)
                begin
                    if (cnt_reg != '1)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    hit_next = 1'b1;
                    cd_next  = CdW'(len - 1'b1);
                end
            end
            mwoc_pkg::OP_EOL:
            begin
                cd_next = '0;
            end
            mwoc_pkg::OP_CLEAR:
            begin
                cnt_next = '0;
            end
            default:
            begin
                cd_next = cd_reg;
            end
        endcase
    end

    // Slot state; the counter and hit flag also serve as the result payload.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cd_reg  <= '0;
            cnt_reg <= '0;
            hit_reg <= 1'b0;
        end
        else if (ctl.step)
        begin
            cd_reg  <= cd_next;
            cnt_reg <= cnt_next;
            hit_reg <= hit_next;
        end
    end

    assign count = cnt_reg;
    assign hit   = hit_reg;

endmodule
